// ===== rtl/cte_pkg.sv =====
package cte_pkg;

  localparam int YEAR_MIN     = 1970;
  localparam int YEAR_MAX     = 9999;
  localparam int MONTH_MAX    = 12;
  localparam int HOUR_MAX     = 23;
  localparam int MINUTE_MAX   = 59;
  localparam int SECOND_MAX   = 59;
  localparam int MILLI_MAX    = 999;
  localparam int OFFSET_LIMIT = 1440;

  // Reciprocal of 100 for 14-bit values: (x * RECIP100) >> RECIP_SHIFT == x / 100.
  localparam int RECIP100    = 5243;
  localparam int RECIP_SHIFT = 19;

  // Days from 0000-03-01 to 1970-01-01, plus one for the one-based day of month.
  localparam int DAYS_OFFSET = 719469;

  localparam logic [3:0] MONTH_FEB    = 4'd2;
  localparam logic [1:0] DST_SUBTRACT = 2'd1;

  localparam int YEAR_W  = 14;
  localparam int Q_W     = 8;
  localparam int DAYS_W  = 23;
  localparam int TOD_W   = 17;
  localparam int ADJ_W   = 18;
  localparam int EPOCH_W = 39;
  localparam int MICRO_W = 20;

  typedef struct packed {
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         milli;
    logic               is_utc;
    logic signed [11:0] zone_offset_min;
    logic [1:0]         dst_code;
  } cte_item_t;

  typedef struct packed {
    logic                     range_ok;
    logic [YEAR_W-1:0]        year;
    logic [3:0]               month;
    logic [4:0]               day;
    logic [Q_W-1:0]           q_year;
    logic [Q_W-1:0]           q_yy;
    logic [DAYS_W-1:0]        yy_days;
    logic [8:0]               month_base;
    logic [TOD_W-1:0]         tod;
    logic [MICRO_W-1:0]       micros;
    logic signed [ADJ_W-1:0]  adj;
  } cte_s1_t;

  typedef struct packed {
    logic                     ok;
    logic [DAYS_W-1:0]        days;
    logic [TOD_W-1:0]         tod;
    logic [MICRO_W-1:0]       micros;
    logic signed [ADJ_W-1:0]  adj;
  } cte_s2_t;

  typedef struct packed {
    logic                      ok;
    logic signed [EPOCH_W-1:0] epoch_seconds;
    logic [MICRO_W-1:0]        micros;
  } cte_result_t;

  // Days from March 1 to the first of the month, in a year that starts in March.
  function automatic logic [8:0] month_base(input logic [3:0] m);
    logic [8:0] b;
    unique case (m)
      4'd3:    b = 9'd0;
      4'd4:    b = 9'd31;
      4'd5:    b = 9'd61;
      4'd6:    b = 9'd92;
      4'd7:    b = 9'd122;
      4'd8:    b = 9'd153;
      4'd9:    b = 9'd184;
      4'd10:   b = 9'd214;
      4'd11:   b = 9'd245;
      4'd12:   b = 9'd275;
      4'd1:    b = 9'd306;
      4'd2:    b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      MONTH_FEB:                                   n = leap ? 5'd29 : 5'd28;
      default:                                     n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/cte_field_stage.sv =====
module cte_field_stage
  import cte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cte_item_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output cte_s1_t   out_data
);

  logic                    valid;
  cte_s1_t                 data;
  cte_s1_t                 data_next;
  logic [YEAR_W-1:0]       yy;
  logic [26:0]             prod_year;
  logic [26:0]             prod_yy;
  logic signed [11:0]      off_sat;
  logic signed [ADJ_W-1:0] off60;
  logic signed [ADJ_W-1:0] dst_adj;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    yy = (in_data.month <= MONTH_FEB) ? in_data.year - YEAR_W'(1) : in_data.year;
    prod_year = 27'(in_data.year) * 27'(RECIP100);
    prod_yy   = 27'(yy) * 27'(RECIP100);

    if (in_data.zone_offset_min > 12'sd1440) begin
      off_sat = 12'sd1440;
    end else if (in_data.zone_offset_min < -12'sd1440) begin
      off_sat = -12'sd1440;
    end else begin
      off_sat = in_data.zone_offset_min;
    end
    off60   = ADJ_W'(off_sat) * 18'sd60;
    dst_adj = (in_data.dst_code == DST_SUBTRACT) ? 18'sd3600 : 18'sd0;

    data_next.range_ok = (in_data.year >= YEAR_W'(YEAR_MIN)) &&
                         (in_data.year <= YEAR_W'(YEAR_MAX)) &&
                         (in_data.month >= 4'd1) && (in_data.month <= 4'(MONTH_MAX)) &&
                         (in_data.day >= 5'd1) &&
                         (in_data.hour <= 5'(HOUR_MAX)) &&
                         (in_data.minute <= 6'(MINUTE_MAX)) &&
                         (in_data.second <= 6'(SECOND_MAX)) &&
                         (in_data.milli <= 10'(MILLI_MAX));
    data_next.year       = in_data.year;
    data_next.month      = in_data.month;
    data_next.day        = in_data.day;
    data_next.q_year     = prod_year[RECIP_SHIFT +: Q_W];
    data_next.q_yy       = prod_yy[RECIP_SHIFT +: Q_W];
    data_next.yy_days    = DAYS_W'(yy) * DAYS_W'(365) + DAYS_W'(yy[YEAR_W-1:2]);
    data_next.month_base = month_base(in_data.month);
    data_next.tod        = TOD_W'(in_data.hour) * TOD_W'(3600) +
                           TOD_W'(in_data.minute) * TOD_W'(60) + TOD_W'(in_data.second);
    data_next.micros     = MICRO_W'(in_data.milli) * MICRO_W'(1000);
    data_next.adj        = in_data.is_utc ? 18'sd0 : off60 + dst_adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== rtl/cte_date_stage.sv =====
module cte_date_stage
  import cte_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  cte_s1_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output cte_s2_t out_data
);

  logic              valid;
  cte_s2_t           data;
  cte_s2_t           data_next;
  logic [YEAR_W-1:0] rem100;
  logic              leap;
  logic [4:0]        mlen;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_comb begin
    rem100 = in_data.year - YEAR_W'(in_data.q_year) * YEAR_W'(100);
    leap   = (in_data.year[1:0] == 2'd0) &&
             ((rem100 != '0) || (in_data.q_year[1:0] == 2'd0));
    mlen   = month_len(in_data.month, leap);

    data_next.ok     = in_data.range_ok && (in_data.day <= mlen);
    data_next.days   = in_data.yy_days - DAYS_W'(in_data.q_yy) +
                       DAYS_W'(in_data.q_yy[Q_W-1:2]) + DAYS_W'(in_data.month_base) +
                       DAYS_W'(in_data.day) - DAYS_W'(DAYS_OFFSET);
    data_next.tod    = in_data.tod;
    data_next.micros = in_data.micros;
    data_next.adj    = in_data.adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== rtl/cte_sum_stage.sv =====
module cte_sum_stage
  import cte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cte_s2_t     in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output cte_result_t out_data
);

  logic                    scale_valid;
  logic                    scale_ready;
  logic [EPOCH_W-1:0]      day_secs;
  logic [EPOCH_W-1:0]      day_secs_next;
  logic                    ok;
  logic [TOD_W-1:0]        tod;
  logic [MICRO_W-1:0]      micros;
  logic signed [ADJ_W-1:0] adj;
  logic                    valid;
  cte_result_t             data;
  cte_result_t             data_next;

  assign in_ready    = !scale_valid || scale_ready;
  assign scale_ready = !valid || out_ready;
  assign out_valid   = valid;
  assign out_data    = data;

  assign day_secs_next = EPOCH_W'(in_data.days) * EPOCH_W'(86400);

  always_comb begin
    data_next.ok            = ok;
    data_next.epoch_seconds = '0;
    data_next.micros        = '0;
    if (ok) begin
      data_next.epoch_seconds = day_secs + EPOCH_W'(tod) -
                                {{(EPOCH_W-ADJ_W){adj[ADJ_W-1]}}, adj};
      data_next.micros        = micros;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_valid <= 1'b0;
      valid       <= 1'b0;
    end else begin
      if (in_ready) begin
        scale_valid <= in_valid;
      end
      if (scale_ready) begin
        valid <= scale_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      day_secs <= day_secs_next;
      ok       <= in_data.ok;
      tod      <= in_data.tod;
      micros   <= in_data.micros;
      adj      <= in_data.adj;
    end
    if (scale_ready) begin
      data <= data_next;
    end
  end

endmodule

// ===== rtl/calendar_to_epoch_converter.sv =====
// Converts a Gregorian date and time of day into Unix seconds and microseconds, one transfer
// per clock while the output is not stalled; the four register stages (field checks and
// constant products, leap year and day count, the day-to-seconds multiply, the final sum)
// each hold one item, so a stalled output backs up without losing data. Dates outside 1970
// to 9999 or with any field out of range return ok low and zero time fields. Local times
// have the zone offset, clamped to plus or minus 1440 minutes, and one hour for daylight
// saving code 1 subtracted; UTC times ignore both.
module calendar_to_epoch_converter
  import cte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // year, month, day, hour, minute, second, milli, zone_offset_min, dst_code
  input  logic [63:0] s_tdata,
  // is_utc
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // epoch_seconds, micros, zero padding
  output logic [63:0] m_tdata,
  // ok
  output logic        m_tuser
);

  cte_item_t   item;
  logic        s1_valid;
  logic        s1_ready;
  cte_s1_t     s1_data;
  logic        s2_valid;
  logic        s2_ready;
  cte_s2_t     s2_data;
  cte_result_t result;

  assign item.year            = s_tdata[13:0];
  assign item.month           = s_tdata[17:14];
  assign item.day             = s_tdata[22:18];
  assign item.hour            = s_tdata[27:23];
  assign item.minute          = s_tdata[33:28];
  assign item.second          = s_tdata[39:34];
  assign item.milli           = s_tdata[49:40];
  assign item.is_utc          = s_tuser;
  assign item.zone_offset_min = s_tdata[61:50];
  assign item.dst_code        = s_tdata[63:62];

  cte_field_stage u_field (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (item),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .out_data  (s1_data)
  );

  cte_date_stage u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .in_data   (s1_data),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .out_data  (s2_data)
  );

  cte_sum_stage u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_ready  (s2_ready),
    .in_data   (s2_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (result)
  );

  assign m_tdata = {5'b0, result.micros, result.epoch_seconds};
  assign m_tuser = result.ok;

endmodule
